// ===== rtl/otsu_pkg.sv =====
// Shared constants, controller state and command/status types for the Otsu threshold finder.
package otsu_pkg;

   localparam int PIX_W               = 8;
   localparam int FRAC_W              = 4;
   localparam int MEAN_W              = PIX_W + FRAC_W;
   localparam int GRAY_LEVELS_DEF     = 256;
   localparam int LOG2_MAX_PIXELS_DEF = 20;

   typedef enum logic [19:0] {
      ST_CLEAR     = 20'h00001,
      ST_ACCUM     = 20'h00002,
      ST_DRAIN     = 20'h00004,
      ST_SUM_RD    = 20'h00008,
      ST_SUM_MUL   = 20'h00010,
      ST_SUM_ADD   = 20'h00020,
      ST_B_RD      = 20'h00040,
      ST_B_MUL     = 20'h00080,
      ST_B_ACC     = 20'h00100,
      ST_DIVB_GO   = 20'h00200,
      ST_DIVB_WAIT = 20'h00400,
      ST_DIVF_GO   = 20'h00800,
      ST_DIVF_WAIT = 20'h01000,
      ST_DIFF      = 20'h02000,
      ST_MUL1      = 20'h04000,
      ST_MUL2      = 20'h08000,
      ST_MUL3      = 20'h10000,
      ST_CMP       = 20'h20000,
      ST_FINISH    = 20'h40000
   } state_type;

   typedef struct packed {
      logic accum;
      logic clr_we;
      logic t_rst;
      logic t_inc;
      logic acc_clr;
      logic sum_mul;
      logic sum_add;
      logic b_rd;
      logic b_mul;
      logic b_acc;
      logic stop_set;
      logic div_start;
      logic div_sel_f;
      logic mb_load;
      logic diff;
      logic mul1;
      logic mul2;
      logic mul3;
      logic cmp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic t_last;
      logic wb_zero;
      logic wb_full;
      logic stop;
      logic div_busy;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/otsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module otsu_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/otsu_ctrl.sv =====
// Controller state machine: histogram clear, accumulation and threshold sweep sequencing.
module otsu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  otsu_pkg::status_type status,
   output otsu_pkg::cmd_type    cmd
);

   otsu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otsu_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         otsu_pkg::ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (status.t_last) begin
               cmd.t_rst = 1'b1;
               state_in  = otsu_pkg::ST_ACCUM;
            end else begin
               cmd.t_inc = 1'b1;
            end
         end
         otsu_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (req_valid && req_last) begin
               state_in = otsu_pkg::ST_DRAIN;
            end
         end
         otsu_pkg::ST_DRAIN: begin
            cmd.acc_clr = 1'b1;
            cmd.t_rst   = 1'b1;
            state_in    = otsu_pkg::ST_SUM_RD;
         end
         otsu_pkg::ST_SUM_RD: begin
            state_in = otsu_pkg::ST_SUM_MUL;
         end
         otsu_pkg::ST_SUM_MUL: begin
            cmd.sum_mul = 1'b1;
            state_in    = otsu_pkg::ST_SUM_ADD;
         end
         otsu_pkg::ST_SUM_ADD: begin
            cmd.sum_add = 1'b1;
            if (status.t_last) begin
               cmd.t_rst = 1'b1;
               state_in  = otsu_pkg::ST_B_RD;
            end else begin
               cmd.t_inc = 1'b1;
               state_in  = otsu_pkg::ST_SUM_RD;
            end
         end
         otsu_pkg::ST_B_RD: begin
            cmd.b_rd = 1'b1;
            state_in = otsu_pkg::ST_B_MUL;
         end
         otsu_pkg::ST_B_MUL: begin
            cmd.b_mul = 1'b1;
            state_in  = otsu_pkg::ST_B_ACC;
         end
         otsu_pkg::ST_B_ACC: begin
            cmd.b_acc = 1'b1;
            if (!status.stop && !status.wb_zero && !status.wb_full) begin
               state_in = otsu_pkg::ST_DIVB_GO;
            end else begin
               cmd.stop_set = !status.stop && !status.wb_zero;
               if (status.t_last) begin
                  state_in = otsu_pkg::ST_FINISH;
               end else begin
                  cmd.t_inc = 1'b1;
                  state_in  = otsu_pkg::ST_B_RD;
               end
            end
         end
         otsu_pkg::ST_DIVB_GO: begin
            cmd.div_start = 1'b1;
            state_in      = otsu_pkg::ST_DIVB_WAIT;
         end
         otsu_pkg::ST_DIVB_WAIT: begin
            if (!status.div_busy) begin
               state_in = otsu_pkg::ST_DIVF_GO;
            end
         end
         otsu_pkg::ST_DIVF_GO: begin
            cmd.mb_load   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel_f = 1'b1;
            state_in      = otsu_pkg::ST_DIVF_WAIT;
         end
         otsu_pkg::ST_DIVF_WAIT: begin
            if (!status.div_busy) begin
               state_in = otsu_pkg::ST_DIFF;
            end
         end
         otsu_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = otsu_pkg::ST_MUL1;
         end
         otsu_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = otsu_pkg::ST_MUL2;
         end
         otsu_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = otsu_pkg::ST_MUL3;
         end
         otsu_pkg::ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = otsu_pkg::ST_CMP;
         end
         otsu_pkg::ST_CMP: begin
            cmd.cmp = 1'b1;
            if (status.t_last) begin
               state_in = otsu_pkg::ST_FINISH;
            end else begin
               cmd.t_inc = 1'b1;
               state_in  = otsu_pkg::ST_B_RD;
            end
         end
         otsu_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               cmd.t_rst    = 1'b1;
               state_in     = otsu_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = otsu_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/otsu_dpath.sv =====
// Datapath: histogram accumulation, sums, shared divider, variance and best-threshold tracking.
module otsu_dpath #(
   parameter int GRAY_LEVELS     = otsu_pkg::GRAY_LEVELS_DEF,
   parameter int LOG2_MAX_PIXELS = otsu_pkg::LOG2_MAX_PIXELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [otsu_pkg::PIX_W-1:0]  req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [otsu_pkg::PIX_W-1:0]  rsp_threshold,
   input  otsu_pkg::cmd_type           cmd,
   output otsu_pkg::status_type        status
);

   localparam int AW   = $clog2(GRAY_LEVELS);
   localparam int CW   = LOG2_MAX_PIXELS + 1;
   localparam int SW   = CW + otsu_pkg::PIX_W;
   localparam int DVW  = SW + otsu_pkg::FRAC_W;
   localparam int MW   = otsu_pkg::MEAN_W;
   localparam int DSW  = CW + MW - 1;
   localparam int DDW  = 2 * MW;
   localparam int VW   = 2 * CW + DDW;
   localparam int QCW  = $clog2(MW);

   logic          accept;
   logic [AW-1:0] in_addr;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [CW-1:0] wdata, rdata, base;

   logic [AW-1:0] t_ff, t_in;
   logic [CW-1:0] total_ff, total_in;
   logic          s1_valid_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          pw_valid_ff;
   logic [AW-1:0] pw_addr_ff;
   logic [CW-1:0] pw_data_ff;

   logic [SW-1:0] s_ff, sb_ff, prod_ff;
   logic [CW-1:0] wb_ff, wf_ff;
   logic          stop_ff;
   logic [VW-1:0] best_ff, var_val;
   logic [AW-1:0] best_t_ff;
   logic [MW-1:0] mb_ff, d_ff;
   logic [DDW-1:0] dd_ff;
   logic [2*CW-1:0] wbwf_ff;
   logic [VW-1:0] plo_ff, phi_ff;

   logic [DVW-1:0] rem_ff;
   logic [DSW-1:0] dsh_ff;
   logic [MW-1:0]  q_ff;
   logic [QCW-1:0] cnt_ff;
   logic           busy_ff;
   logic [DVW-1:0] dsh_ext;

   logic           rsp_valid_ff;
   logic [otsu_pkg::PIX_W-1:0] rsp_thr_ff;

   assign accept  = req_valid && cmd.accum;
   assign in_addr = ({1'b0, req_pixel} >= (otsu_pkg::PIX_W + 1)'(GRAY_LEVELS))
                  ? AW'(GRAY_LEVELS - 1) : req_pixel[AW-1:0];

   assign base  = (pw_valid_ff && (pw_addr_ff == s1_addr_ff)) ? pw_data_ff : rdata;
   assign raddr = accept ? in_addr : t_ff;
   assign we    = s1_valid_ff || cmd.clr_we || cmd.b_rd;
   assign waddr = s1_valid_ff ? s1_addr_ff : t_ff;
   assign wdata = s1_valid_ff ? (base + CW'(1)) : '0;

   otsu_ram #(
      .WIDTH (CW),
      .DEPTH (GRAY_LEVELS)
   ) u_hist (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      t_in = t_ff;
      if (cmd.t_rst) begin
         t_in = '0;
      end else if (cmd.t_inc) begin
         t_in = t_ff + AW'(1);
      end
      total_in = total_ff;
      if (cmd.out_load) begin
         total_in = '0;
      end else if (accept && !total_ff[CW-1]) begin
         total_in = total_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         pw_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         t_ff        <= t_in;
         total_ff    <= total_in;
         s1_valid_ff <= accept && !total_ff[CW-1];
         pw_valid_ff <= s1_valid_ff;
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign dsh_ext = DVW'(dsh_ff);
   assign var_val = plo_ff + phi_ff;

   always_ff @(posedge clock) begin
      s1_addr_ff <= in_addr;
      pw_addr_ff <= s1_addr_ff;
      pw_data_ff <= wdata;

      if (cmd.acc_clr) begin
         s_ff      <= '0;
         wb_ff     <= '0;
         sb_ff     <= '0;
         stop_ff   <= 1'b0;
         best_ff   <= '0;
         best_t_ff <= '0;
      end
      if (cmd.sum_mul || cmd.b_mul) begin
         prod_ff <= SW'(t_ff) * SW'(rdata);
      end
      if (cmd.sum_add) begin
         s_ff <= s_ff + prod_ff;
      end
      if (cmd.b_mul) begin
         wb_ff <= wb_ff + rdata;
      end
      if (cmd.b_acc) begin
         sb_ff <= sb_ff + prod_ff;
         wf_ff <= total_ff - wb_ff;
      end
      if (cmd.stop_set) begin
         stop_ff <= 1'b1;
      end

      if (cmd.div_start) begin
         if (cmd.div_sel_f) begin
            rem_ff <= {s_ff - sb_ff, otsu_pkg::FRAC_W'(0)};
            dsh_ff <= {wf_ff, (MW - 1)'(0)};
         end else begin
            rem_ff <= {sb_ff, otsu_pkg::FRAC_W'(0)};
            dsh_ff <= {wb_ff, (MW - 1)'(0)};
         end
         q_ff   <= '0;
         cnt_ff <= QCW'(MW - 1);
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ext) begin
            rem_ff <= rem_ff - dsh_ext;
            q_ff   <= {q_ff[MW-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[MW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - QCW'(1);
      end
      if (cmd.mb_load) begin
         mb_ff <= q_ff;
      end
      if (cmd.diff) begin
         d_ff <= (mb_ff > q_ff) ? (mb_ff - q_ff) : (q_ff - mb_ff);
      end
      if (cmd.mul1) begin
         wbwf_ff <= (2 * CW)'(wb_ff) * (2 * CW)'(wf_ff);
         dd_ff   <= DDW'(d_ff) * DDW'(d_ff);
      end
      if (cmd.mul2) begin
         plo_ff <= VW'(VW'(wbwf_ff[CW-1:0]) * VW'(dd_ff));
      end
      if (cmd.mul3) begin
         phi_ff <= VW'(VW'(wbwf_ff[2*CW-1:CW]) * VW'(dd_ff)) << CW;
      end
      if (cmd.cmp && (var_val > best_ff)) begin
         best_ff   <= var_val;
         best_t_ff <= t_ff;
      end
      if (cmd.out_load) begin
         rsp_thr_ff <= otsu_pkg::PIX_W'(best_t_ff);
      end
   end

   assign status.t_last   = (t_ff == AW'(GRAY_LEVELS - 1));
   assign status.wb_zero  = (wb_ff == '0);
   assign status.wb_full  = (wb_ff >= total_ff);
   assign status.stop     = stop_ff;
   assign status.div_busy = busy_ff;
   assign status.rsp_busy = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_thr_ff;

endmodule

// ===== rtl/otsu_threshold_finder.sv =====
// Top level: Otsu threshold finder over an 8-bit gray histogram.
// Pixels are accepted one per cycle while a frame is being collected.
// After the last request: a drain state, a pass over all bins for the total sum, then a sweep
// in which skipped bins need no divide and each evaluated bin takes two 12-step divides.
// The result waits in an output register; the next frame is accepted meanwhile.
// Synchronous reset runs a clearing pass over all GRAY_LEVELS entries of the histogram RAM.
module otsu_threshold_finder #(
   parameter int GRAY_LEVELS     = otsu_pkg::GRAY_LEVELS_DEF,
   parameter int LOG2_MAX_PIXELS = otsu_pkg::LOG2_MAX_PIXELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [otsu_pkg::PIX_W-1:0] req_pixel,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [otsu_pkg::PIX_W-1:0] rsp_threshold
);

   otsu_pkg::cmd_type    cmd;
   otsu_pkg::status_type status;

   otsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .status    (status),
      .cmd       (cmd)
   );

   otsu_dpath #(
      .GRAY_LEVELS     (GRAY_LEVELS),
      .LOG2_MAX_PIXELS (LOG2_MAX_PIXELS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_threshold (rsp_threshold),
      .cmd           (cmd),
      .status        (status)
   );

   assign req_ready = cmd.accum;

endmodule

// ===== dv/tb.sv =====
// Testbench for the Otsu threshold finder: directed and random frames checked against a histogram predictor.
`timescale 1ns / 100ps
module tb;

   localparam int PIX_W    = otsu_pkg::PIX_W;
   localparam int FRAC_W   = otsu_pkg::FRAC_W;
   localparam int LEVELS   = otsu_pkg::GRAY_LEVELS_DEF;
   localparam int MAX_PIX  = 1 << otsu_pkg::LOG2_MAX_PIXELS_DEF;
   localparam int WD_LIMIT = 200000;

   class threshold_board;
      int unsigned hist[LEVELS];
      int unsigned count;
      logic [PIX_W-1:0] pending[$];
      int errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         foreach (hist[i]) hist[i] = 0;
         count = 0;
      endfunction

      function logic [PIX_W-1:0] best_threshold();
         longint unsigned total_sum, wb, sb, wf, mb, mf, d, v, best_v;
         int unsigned best_t;
         total_sum = 0; wb = 0; sb = 0; best_v = 0; best_t = 0;
         for (int t = 0; t < LEVELS; t++) total_sum += longint'(t) * hist[t];
         for (int t = 0; t < LEVELS; t++) begin
            wb += hist[t];
            if (wb == 0) continue;
            if (wb >= count) break;
            wf = count - wb;
            sb += longint'(t) * hist[t];
            mb = (sb << FRAC_W) / wb;
            mf = ((total_sum - sb) << FRAC_W) / wf;
            d = (mb > mf) ? mb - mf : mf - mb;
            v = wb * wf * d * d;
            if (v > best_v) begin
               best_v = v;
               best_t = t;
            end
         end
         return best_t[PIX_W-1:0];
      endfunction

      function void note_request(logic [PIX_W-1:0] pix, logic last);
         int unsigned p;
         p = (pix >= LEVELS) ? LEVELS - 1 : pix;
         if (count < MAX_PIX) begin
            hist[p]++;
            count++;
         end
         if (last) begin
            pending.push_back(best_threshold());
            clear();
         end
      endfunction

      function void check_result(logic [PIX_W-1:0] thr);
         logic [PIX_W-1:0] exp_thr;
         if (pending.size() == 0) begin
            $error("threshold: unexpected result %0d", thr);
            errors++;
            return;
         end
         exp_thr = pending.pop_front();
         if (thr !== exp_thr) begin
            $error("threshold: expected %0d actual %0d", exp_thr, thr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_last = 0;
   logic [PIX_W-1:0] req_pixel = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [PIX_W-1:0] rsp_threshold;

   threshold_board board = new();
   bit calm = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   otsu_threshold_finder dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_pixel, req_last);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_threshold);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_LIMIT) begin
         $display("FAIL otsu_threshold_finder");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 7);
   end

   task automatic send(logic [PIX_W-1:0] pix, logic last);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pixel <= pix;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   task automatic random_frame(int n, int mode);
      int base;
      base = $urandom_range(255);
      for (int i = 0; i < n; i++) begin
         logic [PIX_W-1:0] p;
         case (mode)
            0: p = $urandom_range(255);
            1: p = ($urandom_range(1)) ? base[7:0] : 8'(base + 64 + $urandom_range(20));
            2: p = base[7:0];
            default: p = 8'(base + $urandom_range(3));
         endcase
         send(p, i == n - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed frames
      send(8'd0, 1);
      send(8'd255, 1);
      send(8'd0, 0); send(8'd255, 1);
      send(8'd7, 0); send(8'd7, 0); send(8'd7, 1);
      send(8'd0, 0); send(8'd0, 0); send(8'd255, 0); send(8'd255, 1);
      send(8'd10, 0); send(8'd20, 0); send(8'd30, 0); send(8'd40, 1);
      send(8'hAA, 0); send(8'h55, 0); send(8'h01, 0); send(8'hFE, 1);
      drain();
      send(8'd3, 0);
      drain();
      send(8'd200, 1);
      // fill the block while the receiver holds off
      hold_rsp = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            for (int f = 0; f < 4; f++) random_frame($urandom_range(2, 8), 0);
            drain();
         end
      join
      drain();
      calm = 1;
      for (int f = 0; f < 30; f++) random_frame($urandom_range(1, 6), f % 4);
      calm = 0;
      for (int f = 0; f < 130; f++) random_frame($urandom_range(1, 10), $urandom_range(3));
      drain();
      repeat (4000) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS otsu_threshold_finder");
      else
         $display("FAIL otsu_threshold_finder");
      $finish;
   end
endmodule
